>>> src/mtrr_memory_type_resolver_macros.svh
// Assertion macros shared by the memory type resolver RTL.
// Used by mtrr_head.sv and mtrr_memory_type_resolver.sv.
`ifndef MTRR_MEMORY_TYPE_RESOLVER_MACROS_SVH
`define MTRR_MEMORY_TYPE_RESOLVER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MTRR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtrr assertion failed");
// next-cycle implication
`define MTRR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtrr assertion failed");
`else
`define MTRR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MTRR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> src/mtrr_pkg.sv
// Types and constants for the memory type resolver.
// No dependencies.
`timescale 1ns / 1ps

package mtrr_pkg;

   localparam int TYPE_W     = 3;
   localparam int PAGE_W     = 18;
   localparam int PAGE_SHIFT = 9;   // 4 KB frames per 2 MB page, log2
   localparam int COUNT_W    = 5;

   localparam logic [TYPE_W-1:0] TYPE_UC = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_WB = 3'd6;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // control word that travels with each beat down the chain
   typedef struct packed {
      logic              valid;
      logic              lookup;
      logic              wr_en;     // load that appends a range
      logic              rejected;
      logic              uc_found;  // result already final (UC)
      logic [TYPE_W-1:0] mem_type;
   } ctl_type;

endpackage

>>> src/mtrr_memory_type_resolver.sv
// Memory type resolver top level: entry stages followed by a chain of range cells.
// Depends on mtrr_pkg, mtrr_head and mtrr_cell.
`timescale 1ns / 1ps
`include "mtrr_memory_type_resolver_macros.svh"

// Resolves the caching type of a 2 MB page against a table of up to MAX_RANGES
// variable ranges. A load beat (req_type 0) appends a valid, non write-back
// range whose end frame is base plus the size given by the lowest set mask bit,
// minus one, saturated at all ones; a full table or zero mask flags
// rsp_load_rejected. A lookup beat (req_type 1) returns UC for page 0, else UC
// if any held range overlaps as UC, else the type of the last overlapping range,
// else WB. Every beat gives exactly one result beat, in order. Beats enter one
// per cycle while req_stall is low; each passes the two entry stages and then
// every range cell in turn. The whole chain moves as one: while the output beat
// is held by rsp_stall, nothing advances and req_stall is high.
// The range table lives in the cells themselves, one slot per cell, and a
// load writes its slot as it passes, ahead of any later lookup.

module mtrr_memory_type_resolver #(
   parameter int MAX_RANGES = 16,
   parameter int FRAME_BITS = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic                         req_range_valid,
   input  logic [FRAME_BITS-1:0]        req_range_base_frame,
   input  logic [FRAME_BITS-1:0]        req_range_mask_frame,
   input  logic [mtrr_pkg::TYPE_W-1:0]  req_range_type,
   input  logic [mtrr_pkg::PAGE_W-1:0]  req_page_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mtrr_pkg::TYPE_W-1:0]  rsp_mem_type,
   output logic [mtrr_pkg::COUNT_W-1:0] rsp_range_count,
   output logic                         rsp_load_rejected
);
   import mtrr_pkg::*;

   // count must hold MAX_RANGES itself
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   // compare width covers both frame numbers and page frame bounds
   localparam int CMP_W = (FRAME_BITS > PAGE_W + PAGE_SHIFT) ? FRAME_BITS
                                                             : PAGE_W + PAGE_SHIFT;

   logic adv, accept;

   ctl_type               ctl   [MAX_RANGES+1];
   logic [CNT_W-1:0]      cnt   [MAX_RANGES+1];
   logic [FRAME_BITS-1:0] base  [MAX_RANGES+1];
   logic [FRAME_BITS-1:0] last  [MAX_RANGES+1];
   logic [TYPE_W-1:0]     kind  [MAX_RANGES+1];
   logic [CMP_W-1:0]      first [MAX_RANGES+1];
   logic [CMP_W-1:0]      pend  [MAX_RANGES+1];

   // chain moves unless the output beat is held
   assign adv       = !ctl[MAX_RANGES].valid || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   mtrr_head #(
      .MAX_RANGES (MAX_RANGES),
      .FRAME_BITS (FRAME_BITS),
      .CNT_W      (CNT_W),
      .CMP_W      (CMP_W)
   ) u_head (
      .clock                (clock),
      .reset                (reset),
      .adv                  (adv),
      .accept               (accept),
      .req_type             (req_type),
      .req_range_valid      (req_range_valid),
      .req_range_base_frame (req_range_base_frame),
      .req_range_mask_frame (req_range_mask_frame),
      .req_range_type       (req_range_type),
      .req_page_index       (req_page_index),
      .ctl_o                (ctl[0]),
      .cnt_o                (cnt[0]),
      .base_o               (base[0]),
      .last_o               (last[0]),
      .kind_o               (kind[0]),
      .first_o              (first[0]),
      .end_o                (pend[0])
   );

   // cell i holds the range appended i-th
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      mtrr_cell #(
         .FRAME_BITS (FRAME_BITS),
         .CNT_W      (CNT_W),
         .CMP_W      (CMP_W),
         .INDEX      (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .ctl_i   (ctl[i]),
         .cnt_i   (cnt[i]),
         .base_i  (base[i]),
         .last_i  (last[i]),
         .kind_i  (kind[i]),
         .first_i (first[i]),
         .end_i   (pend[i]),
         .ctl_o   (ctl[i+1]),
         .cnt_o   (cnt[i+1]),
         .base_o  (base[i+1]),
         .last_o  (last[i+1]),
         .kind_o  (kind[i+1]),
         .first_o (first[i+1]),
         .end_o   (pend[i+1])
      );
   end

   // last cell's registers are the output beat
   assign rsp_valid         = ctl[MAX_RANGES].valid;
   assign rsp_mem_type      = ctl[MAX_RANGES].mem_type;
   assign rsp_range_count   = COUNT_W'(cnt[MAX_RANGES]);
   assign rsp_load_rejected = ctl[MAX_RANGES].rejected;

   `MTRR_ASSERT_IMP(a_rej_no_type, clock, reset, rsp_valid && rsp_load_rejected, rsp_mem_type == TYPE_UC)
   `MTRR_ASSERT_IMP(a_stall_follows, clock, reset, rsp_valid && rsp_stall, req_stall)
   `MTRR_ASSERT_NXT(a_out_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_range_count))

endmodule

>>> src/mtrr_head.sv
// Entry stages: load decode, count update, range end and page bounds.
// Depends on mtrr_pkg.
`timescale 1ns / 1ps
`include "mtrr_memory_type_resolver_macros.svh"

module mtrr_head #(
   parameter int MAX_RANGES = 16,
   parameter int FRAME_BITS = 40,
   parameter int CNT_W      = 5,
   parameter int CMP_W      = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          accept,
   input  logic                          req_type,
   input  logic                          req_range_valid,
   input  logic [FRAME_BITS-1:0]         req_range_base_frame,
   input  logic [FRAME_BITS-1:0]         req_range_mask_frame,
   input  logic [mtrr_pkg::TYPE_W-1:0]   req_range_type,
   input  logic [mtrr_pkg::PAGE_W-1:0]   req_page_index,
   output mtrr_pkg::ctl_type             ctl_o,
   output logic [CNT_W-1:0]              cnt_o,
   output logic [FRAME_BITS-1:0]         base_o,
   output logic [FRAME_BITS-1:0]         last_o,
   output logic [mtrr_pkg::TYPE_W-1:0]   kind_o,
   output logic [CMP_W-1:0]              first_o,
   output logic [CMP_W-1:0]              end_o
);
   import mtrr_pkg::*;

   logic [CNT_W-1:0]      count_ff, count_in;
   ctl_type               ctl0_ff, ctl0_in;
   logic [CNT_W-1:0]      cnt0_ff;
   logic [FRAME_BITS-1:0] base0_ff, span0_ff, span0_in;
   logic [TYPE_W-1:0]     kind0_ff;
   logic [PAGE_W-1:0]     page0_ff;
   logic                  do_load, room, append;

   ctl_type               ctl1_ff, ctl1_in;
   logic [CNT_W-1:0]      cnt1_ff;
   logic [FRAME_BITS-1:0] base1_ff, last1_ff, last1_in;
   logic [TYPE_W-1:0]     kind1_ff;
   logic [CMP_W-1:0]      first1_ff, first1_in, end1_ff, end1_in;
   logic [FRAME_BITS:0]   sum;

   // stage 0: decode the beat, bump the count at acceptance
   always_comb begin
      do_load  = (req_type == REQ_LOAD) && req_range_valid && (req_range_type != TYPE_WB);
      room     = count_ff < CNT_W'(MAX_RANGES);
      append   = do_load && room && (req_range_mask_frame != '0);
      count_in = count_ff + CNT_W'(append);
      // ones below the lowest set mask bit
      span0_in = ~req_range_mask_frame & (req_range_mask_frame - FRAME_BITS'(1));
      ctl0_in          = '0;
      ctl0_in.valid    = accept;
      ctl0_in.lookup   = (req_type == REQ_LOOKUP);
      ctl0_in.wr_en    = append;
      ctl0_in.rejected = do_load && !append;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ctl0_ff  <= '0;
      end else if (adv) begin
         ctl0_ff <= ctl0_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cnt0_ff  <= count_in;
         base0_ff <= req_range_base_frame;
         span0_ff <= span0_in;
         kind0_ff <= req_range_type;
         page0_ff <= req_page_index;
      end
   end

   // stage 1: saturating range end, page frame bounds, default type
   always_comb begin
      sum       = {1'b0, base0_ff} + {1'b0, span0_ff};
      last1_in  = sum[FRAME_BITS] ? '1 : sum[FRAME_BITS-1:0];
      first1_in = CMP_W'(page0_ff) << PAGE_SHIFT;
      end1_in   = first1_in | CMP_W'((1 << PAGE_SHIFT) - 1);
      ctl1_in   = ctl0_ff;
      if (ctl0_ff.lookup) begin
         if (page0_ff == '0) begin
            ctl1_in.mem_type = TYPE_UC;
            ctl1_in.uc_found = 1'b1;
         end else begin
            ctl1_in.mem_type = TYPE_WB;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cnt1_ff   <= cnt0_ff;
         base1_ff  <= base0_ff;
         last1_ff  <= last1_in;
         kind1_ff  <= kind0_ff;
         first1_ff <= first1_in;
         end1_ff   <= end1_in;
      end
   end

   assign ctl_o   = ctl1_ff;
   assign cnt_o   = cnt1_ff;
   assign base_o  = base1_ff;
   assign last_o  = last1_ff;
   assign kind_o  = kind1_ff;
   assign first_o = first1_ff;
   assign end_o   = end1_ff;

   `MTRR_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_RANGES))
   `MTRR_ASSERT_NXT(a_count_hold, clock, reset, !(accept && append), $stable(count_ff))
   `MTRR_ASSERT_IMP(a_wr_xor_rej, clock, reset, ctl0_ff.valid, !(ctl0_ff.wr_en && ctl0_ff.rejected))

endmodule

>>> src/mtrr_cell.sv
// One range slot of the chain: stores a range, checks lookups against it.
// Depends on mtrr_pkg.
`timescale 1ns / 1ps

module mtrr_cell #(
   parameter int FRAME_BITS = 40,
   parameter int CNT_W      = 5,
   parameter int CMP_W      = 40,
   parameter int INDEX      = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  mtrr_pkg::ctl_type            ctl_i,
   input  logic [CNT_W-1:0]             cnt_i,
   input  logic [FRAME_BITS-1:0]        base_i,
   input  logic [FRAME_BITS-1:0]        last_i,
   input  logic [mtrr_pkg::TYPE_W-1:0]  kind_i,
   input  logic [CMP_W-1:0]             first_i,
   input  logic [CMP_W-1:0]             end_i,
   output mtrr_pkg::ctl_type            ctl_o,
   output logic [CNT_W-1:0]             cnt_o,
   output logic [FRAME_BITS-1:0]        base_o,
   output logic [FRAME_BITS-1:0]        last_o,
   output logic [mtrr_pkg::TYPE_W-1:0]  kind_o,
   output logic [CMP_W-1:0]             first_o,
   output logic [CMP_W-1:0]             end_o
);
   import mtrr_pkg::*;

   logic [FRAME_BITS-1:0] start_ff, last_ff;
   logic [TYPE_W-1:0]     kind_ff;
   ctl_type               ctl_ff, ctl_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [FRAME_BITS-1:0] base_ff, lastp_ff;
   logic [TYPE_W-1:0]     kindp_ff;
   logic [CMP_W-1:0]      first_ff, end_ff;
   logic                  sel, hit;

   always_comb begin
      // this slot is the one appended by a load whose count lands on INDEX+1
      sel = ctl_i.valid && ctl_i.wr_en && (cnt_i == CNT_W'(INDEX + 1));
      hit = ctl_i.valid && ctl_i.lookup && !ctl_i.uc_found
            && (CNT_W'(INDEX) < cnt_i)
            && (first_i <= CMP_W'(last_ff)) && (end_i >= CMP_W'(start_ff));
      ctl_in = ctl_i;
      if (hit) begin
         ctl_in.mem_type = kind_ff;
         ctl_in.uc_found = (kind_ff == TYPE_UC);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && sel) begin
         start_ff <= base_i;
         last_ff  <= last_i;
         kind_ff  <= kind_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cnt_ff   <= cnt_i;
         base_ff  <= base_i;
         lastp_ff <= last_i;
         kindp_ff <= kind_i;
         first_ff <= first_i;
         end_ff   <= end_i;
      end
   end

   assign ctl_o   = ctl_ff;
   assign cnt_o   = cnt_ff;
   assign base_o  = base_ff;
   assign last_o  = lastp_ff;
   assign kind_o  = kindp_ff;
   assign first_o = first_ff;
   assign end_o   = end_ff;

endmodule
